// File: sv/gs_grid_pkg.sv
`timescale 1ns / 1ps

package gs_grid_pkg;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_READ  = 2'd2
    } item_kind_t;

    localparam logic ANS_READ = 1'b0;
    localparam logic ANS_STEP = 1'b1;

    typedef enum logic [2:0] {
        CFG_FEED   = 3'd0,
        CFG_KILL   = 3'd1,
        CFG_DIFF_U = 3'd2,
        CFG_DIFF_V = 3'd3,
        CFG_DT     = 3'd4,
        CFG_WRAP   = 3'd5,
        CFG_WIDTH  = 3'd6,
        CFG_HEIGHT = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDWAIT,
        ST_FETCH,
        ST_MATH,
        ST_WB,
        ST_COPY,
        ST_RESP
    } state_t;

    // shift right by 15, rounding half away from zero
    function automatic logic signed [37:0] rnd15(input logic signed [53:0] v);
        logic [53:0] m;
        logic [53:0] r;
        m = v[53] ? 54'(-v) : 54'(v);
        r = (m + 54'd16384) >> 15;
        rnd15 = v[53] ? -$signed(r[37:0]) : $signed(r[37:0]);
    endfunction

    // shift right by 27, rounding half away from zero
    function automatic logic signed [26:0] rnd27(input logic signed [55:0] v);
        logic [55:0] m;
        logic [55:0] r;
        m = v[55] ? 56'(-v) : 56'(v);
        r = (m + 56'd67108864) >> 27;
        rnd27 = v[55] ? -$signed(r[26:0]) : $signed(r[26:0]);
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] old,
                                            input logic signed [26:0] d);
        logic signed [27:0] n;
        n = $signed({12'b0, old}) + 28'(d);
        if (n < 0) begin
            sat_add = 16'd0;
        end else if (n > $signed({12'b0, ONE_Q15})) begin
            sat_add = ONE_Q15;
        end else begin
            sat_add = n[15:0];
        end
    endfunction

endpackage

// File: sv/gs_grid_ram.sv
`timescale 1ns / 1ps

module gs_grid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/gray_scott_grid_step.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_kind s_cell_x s_cell_y s_value_u s_value_v
// m_        out  m_valid/m_ready    m_answer_kind m_read_u m_read_v m_steps_done
// cfg_      in   cfg_wr_en          cfg_index cfg_data
//
// after reset a clearing pass sets all GRID_MAX*GRID_MAX cells, no beat is
// taken meanwhile; config writes are taken at any time
// a read goes through ST_RDWAIT and ST_RESP to the result register
// step: per active cell 5 grid ram reads, 8 passes of the shared multiplier and a
// write back, then the new grid is copied back
// the result waits in an output register; a stalled m_ready holds the block only
// once a new result is ready for it, writes are taken until then

module gray_scott_grid_step
    import gs_grid_pkg::*;
#(
    parameter int GRID_MAX = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_cell_x,
    input  logic [7:0]  s_cell_y,
    input  logic [15:0] s_value_u,
    input  logic [15:0] s_value_v,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_answer_kind,
    output logic [15:0] m_read_u,
    output logic [15:0] m_read_v,
    output logic [31:0] m_steps_done,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(GRID_MAX);
    localparam int AW = 2 * CW;
    localparam int DEPTH = 2 ** AW;
    localparam int EW = (CW + 1 > 9) ? CW + 1 : 9;

    state_t state_reg, state_next;

    logic [15:0] feed_reg, kill_reg, du_reg, dv_reg, dt_reg;
    logic        wrap_reg;
    logic [8:0]  gw_reg, gh_reg;

    logic [CW-1:0] x_reg, y_reg;
    logic [2:0]    nb_reg;
    logic [3:0]    mstep_reg;
    logic [AW-1:0] clr_reg;
    logic          cp_pend_reg, cp_done_reg;
    logic [AW-1:0] cp_addr_reg;
    logic          inside_reg;
    logic [31:0]   step_cnt_reg;

    logic [15:0] nbu_reg [5];
    logic [15:0] nbv_reg [5];
    logic signed [55:0] prod_reg;
    logic signed [53:0] acc_u_reg, acc_v_reg;
    logic signed [37:0] r30u_reg, r30v_reg;
    logic signed [26:0] dn_u_reg, dn_v_reg;

    logic        resp_kind_reg;
    logic [15:0] resp_u_reg, resp_v_reg;
    logic        m_valid_reg, m_kind_reg;
    logic [15:0] m_u_reg, m_v_reg;
    logic [31:0] m_steps_reg;

    logic          grid_we, next_we;
    logic [AW-1:0] grid_waddr, grid_raddr, next_waddr, next_raddr;
    logic [31:0]   grid_wdata, grid_rdata, next_wdata, next_rdata;

    gs_grid_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_grid (
        .aclk(aclk), .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
        .raddr(grid_raddr), .rdata(grid_rdata)
    );

    gs_grid_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_next (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(next_raddr), .rdata(next_rdata)
    );

    // active region, clamped to 8..GRID_MAX
    logic [EW-1:0] gw_ext, gh_ext, eff_w, eff_h, in_x, in_y;
    logic [CW-1:0] wm1, hm1;
    logic          in_inside, s_fire, last_x, last_y, resp_free, cp_finish;

    always_comb begin
        gw_ext = EW'(gw_reg);
        gh_ext = EW'(gh_reg);
        if (gw_ext < EW'(8)) begin
            eff_w = EW'(8);
        end else if (gw_ext > EW'(GRID_MAX)) begin
            eff_w = EW'(GRID_MAX);
        end else begin
            eff_w = gw_ext;
        end
        if (gh_ext < EW'(8)) begin
            eff_h = EW'(8);
        end else if (gh_ext > EW'(GRID_MAX)) begin
            eff_h = EW'(GRID_MAX);
        end else begin
            eff_h = gh_ext;
        end
    end

    assign wm1 = CW'(eff_w - EW'(1));
    assign hm1 = CW'(eff_h - EW'(1));
    assign in_x = EW'(s_cell_x);
    assign in_y = EW'(s_cell_y);
    assign in_inside = (in_x < eff_w) && (in_y < eff_h);
    assign s_fire = s_valid && s_ready;
    assign last_x = (x_reg == wm1);
    assign last_y = (y_reg == hm1);
    assign resp_free = !m_valid_reg || m_ready;
    assign cp_finish = cp_done_reg && !cp_pend_reg;

    // neighbour coordinates
    logic [CW-1:0] x_lo, x_hi, y_lo, y_hi;
    always_comb begin
        x_lo = (x_reg == '0) ? (wrap_reg ? wm1 : '0) : x_reg - CW'(1);
        x_hi = last_x ? (wrap_reg ? '0 : wm1) : x_reg + CW'(1);
        y_lo = (y_reg == '0) ? (wrap_reg ? hm1 : '0) : y_reg - CW'(1);
        y_hi = last_y ? (wrap_reg ? '0 : hm1) : y_reg + CW'(1);
    end

    logic signed [19:0] lap_u, lap_v;
    assign lap_u = $signed({4'b0, nbu_reg[1]}) + $signed({4'b0, nbu_reg[2]})
                 + $signed({4'b0, nbu_reg[3]}) + $signed({4'b0, nbu_reg[4]})
                 - $signed({2'b0, nbu_reg[0], 2'b0});
    assign lap_v = $signed({4'b0, nbv_reg[1]}) + $signed({4'b0, nbv_reg[2]})
                 + $signed({4'b0, nbv_reg[3]}) + $signed({4'b0, nbv_reg[4]})
                 - $signed({2'b0, nbv_reg[0], 2'b0});

    // shared multiplier operands
    logic signed [37:0] mul_a;
    logic signed [17:0] mul_b;
    logic [15:0]        one_minus_u;
    logic [16:0]        fk_sum;
    assign one_minus_u = ONE_Q15 - nbu_reg[0];
    assign fk_sum = {1'b0, feed_reg} + {1'b0, kill_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (mstep_reg)
            4'd0: begin
                mul_a = 38'(lap_u);
                mul_b = $signed({2'b0, du_reg});
            end
            4'd1: begin
                mul_a = 38'(lap_v);
                mul_b = $signed({2'b0, dv_reg});
            end
            4'd2: begin
                mul_a = $signed({22'b0, nbu_reg[0]});
                mul_b = $signed({2'b0, nbv_reg[0]});
            end
            4'd3: begin
                mul_a = $signed(prod_reg[37:0]);
                mul_b = $signed({2'b0, nbv_reg[0]});
            end
            4'd4: begin
                mul_a = $signed({22'b0, one_minus_u});
                mul_b = $signed({2'b0, feed_reg});
            end
            4'd5: begin
                mul_a = $signed({22'b0, nbv_reg[0]});
                mul_b = $signed({1'b0, fk_sum});
            end
            4'd7: begin
                mul_a = r30u_reg;
                mul_b = $signed({2'b0, dt_reg});
            end
            4'd8: begin
                mul_a = r30v_reg;
                mul_b = $signed({2'b0, dt_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == {AW{1'b1}}) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_kind == KIND_STEP) begin
                        state_next = ST_FETCH;
                    end else if (s_kind == KIND_READ) begin
                        state_next = ST_RDWAIT;
                    end
                end
            end
            ST_RDWAIT: state_next = ST_RESP;
            ST_FETCH:  if (nb_reg == 3'd5) state_next = ST_MATH;
            ST_MATH:   if (mstep_reg == 4'd9) state_next = ST_WB;
            ST_WB:     state_next = (last_x && last_y) ? ST_COPY : ST_FETCH;
            ST_COPY:   if (cp_finish) state_next = ST_RESP;
            ST_RESP:   if (resp_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ram controls and ready
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        grid_we    = 1'b0;
        grid_waddr = {y_reg, x_reg};
        grid_wdata = next_rdata;
        grid_raddr = {y_reg, x_reg};
        next_we    = 1'b0;
        next_waddr = {y_reg, x_reg};
        next_wdata = {sat_add(nbu_reg[0], dn_u_reg), sat_add(nbv_reg[0], dn_v_reg)};
        next_raddr = {y_reg, x_reg};
        unique case (state_reg)
            ST_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = clr_reg;
                grid_wdata = {ONE_Q15, 16'd0};
            end
            ST_IDLE: begin
                grid_raddr = {in_y[CW-1:0], in_x[CW-1:0]};
                grid_waddr = {in_y[CW-1:0], in_x[CW-1:0]};
                grid_wdata = {(s_value_u > ONE_Q15) ? ONE_Q15 : s_value_u,
                              (s_value_v > ONE_Q15) ? ONE_Q15 : s_value_v};
                grid_we    = s_fire && (s_kind == KIND_WRITE) && in_inside;
            end
            ST_FETCH: begin
                case (nb_reg)
                    3'd1:    grid_raddr = {y_reg, x_lo};
                    3'd2:    grid_raddr = {y_reg, x_hi};
                    3'd3:    grid_raddr = {y_lo, x_reg};
                    3'd4:    grid_raddr = {y_hi, x_reg};
                    default: grid_raddr = {y_reg, x_reg};
                endcase
            end
            ST_WB: next_we = 1'b1;
            ST_COPY: begin
                grid_we    = cp_pend_reg;
                grid_waddr = cp_addr_reg;
            end
            default: begin
                grid_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            cp_pend_reg  <= 1'b0;
            cp_done_reg  <= 1'b0;
            feed_reg     <= 16'd3572;
            kill_reg     <= 16'd4063;
            du_reg       <= 16'd16384;
            dv_reg       <= 16'd8192;
            dt_reg       <= 16'd4096;
            wrap_reg     <= 1'b1;
            gw_reg       <= 9'd256;
            gh_reg       <= 9'd256;
            nb_reg       <= '0;
            mstep_reg    <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_FEED:   feed_reg <= cfg_data;
                    CFG_KILL:   kill_reg <= cfg_data;
                    CFG_DIFF_U: du_reg   <= cfg_data;
                    CFG_DIFF_V: dv_reg   <= cfg_data;
                    CFG_DT:     dt_reg   <= cfg_data;
                    CFG_WRAP:   wrap_reg <= cfg_data[0];
                    CFG_WIDTH:  gw_reg   <= cfg_data[8:0];
                    CFG_HEIGHT: gh_reg   <= cfg_data[8:0];
                    default:    wrap_reg <= wrap_reg;
                endcase
            end

            // in the response state the result register is handled below
            if (m_valid_reg && m_ready && state_reg != ST_RESP) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + AW'(1);
                ST_IDLE: begin
                    inside_reg <= in_inside;
                    x_reg      <= '0;
                    y_reg      <= '0;
                    nb_reg     <= '0;
                end
                ST_RDWAIT: begin
                    resp_kind_reg <= ANS_READ;
                    resp_u_reg    <= inside_reg ? grid_rdata[31:16] : 16'd0;
                    resp_v_reg    <= inside_reg ? grid_rdata[15:0] : 16'd0;
                end
                ST_FETCH: begin
                    // read data arrives in the cycle after its address
                    if (nb_reg != 3'd0) begin
                        nbu_reg[nb_reg - 3'd1] <= grid_rdata[31:16];
                        nbv_reg[nb_reg - 3'd1] <= grid_rdata[15:0];
                    end
                    nb_reg    <= nb_reg + 3'd1;
                    mstep_reg <= '0;
                end
                ST_MATH: begin
                    prod_reg  <= mul_a * mul_b;
                    mstep_reg <= mstep_reg + 4'd1;
                    case (mstep_reg)
                        4'd1: acc_u_reg <= prod_reg[53:0] <<< 16;
                        4'd2: acc_v_reg <= prod_reg[53:0] <<< 16;
                        4'd4: begin
                            acc_u_reg <= acc_u_reg - prod_reg[53:0];
                            acc_v_reg <= acc_v_reg + prod_reg[53:0];
                        end
                        4'd5: acc_u_reg <= acc_u_reg + (prod_reg[53:0] <<< 14);
                        4'd6: begin
                            acc_v_reg <= acc_v_reg - (prod_reg[53:0] <<< 14);
                            r30u_reg  <= rnd15(acc_u_reg);
                        end
                        4'd7: r30v_reg <= rnd15(acc_v_reg);
                        4'd8: dn_u_reg <= rnd27(prod_reg);
                        4'd9: dn_v_reg <= rnd27(prod_reg);
                        default: dn_v_reg <= dn_v_reg;
                    endcase
                end
                ST_WB: begin
                    nb_reg      <= '0;
                    cp_pend_reg <= 1'b0;
                    cp_done_reg <= 1'b0;
                    if (last_x) begin
                        x_reg <= '0;
                        y_reg <= last_y ? '0 : y_reg + CW'(1);
                    end else begin
                        x_reg <= x_reg + CW'(1);
                    end
                end
                ST_COPY: begin
                    if (!cp_done_reg) begin
                        cp_pend_reg <= 1'b1;
                        cp_addr_reg <= {y_reg, x_reg};
                        if (last_x) begin
                            x_reg <= '0;
                            y_reg <= y_reg + CW'(1);
                            cp_done_reg <= last_y;
                        end else begin
                            x_reg <= x_reg + CW'(1);
                        end
                    end else begin
                        cp_pend_reg <= 1'b0;
                    end
                    if (cp_finish) begin
                        step_cnt_reg  <= step_cnt_reg + 32'd1;
                        resp_kind_reg <= ANS_STEP;
                        resp_u_reg    <= 16'd0;
                        resp_v_reg    <= 16'd0;
                    end
                end
                ST_RESP: begin
                    if (resp_free) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= resp_kind_reg;
                        m_u_reg     <= resp_u_reg;
                        m_v_reg     <= resp_v_reg;
                        m_steps_reg <= step_cnt_reg;
                    end
                end
                default: clr_reg <= clr_reg;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_answer_kind = m_kind_reg;
    assign m_read_u      = m_u_reg;
    assign m_read_v      = m_v_reg;
    assign m_steps_done  = m_steps_reg;

    // the grid is never written while a cell's neighbours are being gathered
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH || state_reg == ST_MATH) |-> !grid_we)
        else $error("grid written during cell update");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MATH) |-> (mstep_reg <= 4'd9))
        else $error("multiplier sequence overran");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && !(s_fire && s_kind == KIND_STEP)) |=>
            $stable(step_cnt_reg))
        else $error("step count moved outside a step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result beat raised outside response state");

endmodule

// File: tb/sv/gray_scott_grid_step_tb.sv
`timescale 1ns / 1ps

module gray_scott_grid_step_tb;
    import gs_grid_pkg::*;

    localparam int GRID_N = 256;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] u;
        logic [15:0] v;
    } cell_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] u;
        logic [15:0] v;
        logic [31:0] steps;
    } answer_t;

    typedef struct {
        cell_item_t item;
        logic       typed;
        answer_t    ans;
    } row_t;

    typedef struct {
        logic [15:0] feed;
        logic [15:0] kill;
        logic [15:0] du;
        logic [15:0] dv;
        logic [15:0] dt;
        logic        wrap;
        logic [8:0]  w;
        logic [8:0]  h;
        int          max_steps;
    } setting_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [7:0]  s_cell_x;
    logic [7:0]  s_cell_y;
    logic [15:0] s_value_u;
    logic [15:0] s_value_v;
    logic        m_valid;
    logic        m_ready;
    logic        m_answer_kind;
    logic [15:0] m_read_u;
    logic [15:0] m_read_v;
    logic [31:0] m_steps_done;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    gray_scott_grid_step #(.GRID_MAX(GRID_N)) dut (.*);

    // predictor state
    logic [15:0] conc_u [0:GRID_N*GRID_N-1];
    logic [15:0] conc_v [0:GRID_N*GRID_N-1];
    logic [15:0] fresh_u [0:GRID_N*GRID_N-1];
    logic [15:0] fresh_v [0:GRID_N*GRID_N-1];
    logic [31:0] step_count;
    logic [15:0] p_feed, p_kill, p_du, p_dv, p_dt;
    logic        p_wrap;
    logic [8:0]  p_w, p_h;

    answer_t answer_q[$];
    int      errors;
    int      beats_in;
    int      reads_seen;
    int      steps_seen;
    int      burst_left;
    int      rx_cycle;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic int eff_dim(logic [8:0] d);
        if (d < 9'd8) return 8;
        if (d > 9'(GRID_N)) return GRID_N;
        return int'(d);
    endfunction

    function automatic longint half_away(longint val, int sh);
        longint m;
        m = (val < 0) ? -val : val;
        m = (m + (longint'(1) << (sh - 1))) >>> sh;
        return (val < 0) ? -m : m;
    endfunction

    function automatic int next_pos(int p, bit up, int n);
        if (up) return (p + 1 < n) ? p + 1 : (p_wrap ? 0 : n - 1);
        return (p > 0) ? p - 1 : (p_wrap ? n - 1 : 0);
    endfunction

    function automatic logic [15:0] integrate_cell(logic [15:0] old, longint rate45);
        longint r30;
        longint d15;
        longint n;
        r30 = half_away(rate45, 15);
        d15 = half_away(r30 * longint'(p_dt), 27);
        n = longint'(old) + d15;
        if (n < 0) n = 0;
        if (n > 32768) n = 32768;
        return n[15:0];
    endfunction

    task automatic advance_grid();
        int w;
        int h;
        int i;
        int l;
        int r;
        int dn;
        int up;
        longint u;
        longint v;
        longint uvv;
        longint lap_u;
        longint lap_v;
        longint du;
        longint dv;
        longint fu;
        longint fkv;
        w = eff_dim(p_w);
        h = eff_dim(p_h);
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                i = y * GRID_N + x;
                l = y * GRID_N + next_pos(x, 1'b0, w);
                r = y * GRID_N + next_pos(x, 1'b1, w);
                dn = next_pos(y, 1'b0, h) * GRID_N + x;
                up = next_pos(y, 1'b1, h) * GRID_N + x;
                u = conc_u[i];
                v = conc_v[i];
                uvv = u * v * v;
                lap_u = longint'(conc_u[l]) + conc_u[r] + conc_u[dn] + conc_u[up] - 4 * u;
                lap_v = longint'(conc_v[l]) + conc_v[r] + conc_v[dn] + conc_v[up] - 4 * v;
                du = longint'(p_du) * lap_u * 65536;
                dv = longint'(p_dv) * lap_v * 65536;
                fu = longint'(p_feed) * (32768 - u) * 16384;
                fkv = (longint'(p_feed) + longint'(p_kill)) * v * 16384;
                fresh_u[i] = integrate_cell(u[15:0], du - uvv + fu);
                fresh_v[i] = integrate_cell(v[15:0], dv + uvv - fkv);
            end
        end
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                conc_u[y * GRID_N + x] = fresh_u[y * GRID_N + x];
                conc_v[y * GRID_N + x] = fresh_v[y * GRID_N + x];
            end
        end
        step_count = step_count + 32'd1;
    endtask

    function automatic bit in_region(cell_item_t it);
        return int'(it.x) < eff_dim(p_w) && int'(it.y) < eff_dim(p_h);
    endfunction

    // sets has_ans when the item yields an answer
    task automatic apply_item(cell_item_t it, output bit has_ans, output answer_t ans);
        int i;
        i = int'(it.y) * GRID_N + int'(it.x);
        has_ans = 1'b0;
        ans = '0;
        case (it.kind)
            KIND_WRITE: begin
                if (in_region(it)) begin
                    conc_u[i] = (it.u > ONE_Q15) ? ONE_Q15 : it.u;
                    conc_v[i] = (it.v > ONE_Q15) ? ONE_Q15 : it.v;
                end
            end
            KIND_STEP: begin
                advance_grid();
                has_ans = 1'b1;
                ans = '{ANS_STEP, 16'd0, 16'd0, step_count};
            end
            KIND_READ: begin
                has_ans = 1'b1;
                ans.kind = ANS_READ;
                ans.u = in_region(it) ? conc_u[i] : 16'd0;
                ans.v = in_region(it) ? conc_v[i] : 16'd0;
                ans.steps = step_count;
            end
            default: ;
        endcase
    endtask

    task automatic send_item(cell_item_t it, bit typed, answer_t typed_ans);
        bit has_ans;
        answer_t ans;
        @(negedge aclk);
        s_valid = 1'b1;
        s_kind = it.kind;
        s_cell_x = it.x;
        s_cell_y = it.y;
        s_value_u = it.u;
        s_value_v = it.v;
        do @(posedge aclk); while (!s_ready);
        beats_in++;
        apply_item(it, has_ans, ans);
        if (has_ans) answer_q.push_back(typed ? typed_ans : ans);
        burst_left--;
        if (burst_left <= 0) begin
            int gap;
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
    endtask

    task automatic cfg_write(cfg_index_t idx, logic [15:0] d);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        case (idx)
            CFG_FEED:   p_feed = d;
            CFG_KILL:   p_kill = d;
            CFG_DIFF_U: p_du = d;
            CFG_DIFF_V: p_dv = d;
            CFG_DT:     p_dt = d;
            CFG_WRAP:   p_wrap = d[0];
            CFG_WIDTH:  p_w = d[8:0];
            CFG_HEIGHT: p_h = d[8:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (answer_q.size() != 0) @(posedge aclk);
        // a trailing write may still be in flight
        repeat (25) @(posedge aclk);
    endtask

    task automatic apply_setting(setting_t st);
        @(negedge aclk);
        s_valid = 1'b0;
        wait_drained();
        cfg_write(CFG_FEED, st.feed);
        cfg_write(CFG_KILL, st.kill);
        cfg_write(CFG_DIFF_U, st.du);
        cfg_write(CFG_DIFF_V, st.dv);
        cfg_write(CFG_DT, st.dt);
        cfg_write(CFG_WRAP, {15'd0, st.wrap});
        cfg_write(CFG_WIDTH, {7'd0, st.w});
        cfg_write(CFG_HEIGHT, {7'd0, st.h});
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic random_items(int count, int max_steps);
        cell_item_t it;
        int done;
        int steps;
        int pick;
        done = 0;
        steps = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) it.kind = KIND_WRITE;
            else if (pick < 80) it.kind = KIND_READ;
            else if (pick < 92) it.kind = KIND_STEP;
            else it.kind = KIND_SPARE;
            if (it.kind == KIND_STEP && steps >= max_steps) it.kind = KIND_READ;
            if ($urandom_range(0, 4) != 0) begin
                it.x = 8'($urandom_range(0, eff_dim(p_w) - 1));
                it.y = 8'($urandom_range(0, eff_dim(p_h) - 1));
            end else begin
                it.x = 8'($urandom_range(0, 255));
                it.y = 8'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                it.u = 16'($urandom_range(0, 32768));
                it.v = 16'($urandom_range(0, 32768));
            end else if (pick < 17) begin
                it.u = $urandom_range(0, 1) ? ONE_Q15 : 16'd0;
                it.v = $urandom_range(0, 1) ? ONE_Q15 : 16'd0;
            end else begin
                it.u = 16'($urandom_range(0, 65535));
                it.v = 16'($urandom_range(0, 65535));
            end
            if (it.kind == KIND_STEP) steps++;
            if (!(it.kind == KIND_SPARE || (it.kind == KIND_WRITE && !in_region(it))))
                done++;
            send_item(it, 1'b0, '0);
        end
    endtask

    // receiver stall pattern: always ready, then random, then a periodic pattern, in turn
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 3)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ((rx_cycle % 7) < 2);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (answer_q.size() == 0) begin
                $error("answer beat with nothing expected");
                errors++;
            end else begin
                answer_t e;
                e = answer_q.pop_front();
                if (m_answer_kind === ANS_STEP) steps_seen++;
                else reads_seen++;
                if (m_answer_kind !== e.kind) begin
                    $error("answer_kind expected %0d got %0d", e.kind, m_answer_kind);
                    errors++;
                end
                if (m_read_u !== e.u) begin
                    $error("read_u expected %0d got %0d", e.u, m_read_u);
                    errors++;
                end
                if (m_read_v !== e.v) begin
                    $error("read_v expected %0d got %0d", e.v, m_read_v);
                    errors++;
                end
                if (m_steps_done !== e.steps) begin
                    $error("steps_done expected %0d got %0d", e.steps, m_steps_done);
                    errors++;
                end
            end
        end
    end

    row_t     rows [23];
    setting_t settings [5];

    initial begin
        rows = '{
            // reset contents, full grid
            '{'{KIND_READ, 8'd0, 8'd0, 16'd0, 16'd0}, 1'b1, '{ANS_READ, ONE_Q15, 16'd0, 32'd0}},
            '{'{KIND_READ, 8'd255, 8'd255, 16'd0, 16'd0}, 1'b1,
              '{ANS_READ, ONE_Q15, 16'd0, 32'd0}},
            '{'{KIND_WRITE, 8'd255, 8'd0, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
            '{'{KIND_READ, 8'd255, 8'd0, 16'd0, 16'd0}, 1'b1, '{ANS_READ, ONE_Q15, ONE_Q15, 32'd0}},
            '{'{KIND_WRITE, 8'd0, 8'd255, 16'd0, 16'd0}, 1'b0, '0},
            '{'{KIND_READ, 8'd0, 8'd255, 16'd0, 16'd0}, 1'b1, '{ANS_READ, 16'd0, 16'd0, 32'd0}},
            '{'{KIND_SPARE, 8'hAA, 8'h55, 16'hAAAA, 16'h5555}, 1'b0, '0},
            '{'{KIND_WRITE, 8'h55, 8'hAA, 16'h5555, 16'h2AAA}, 1'b0, '0},
            '{'{KIND_READ, 8'h55, 8'hAA, 16'd0, 16'd0}, 1'b1,
              '{ANS_READ, 16'h5555, 16'h2AAA, 32'd0}},
            '{'{KIND_READ, 8'hAA, 8'h55, 16'd0, 16'd0}, 1'b1, '{ANS_READ, ONE_Q15, 16'd0, 32'd0}},
            // 8 by 8 grid from here
            '{'{KIND_READ, 8'd8, 8'd0, 16'd0, 16'd0}, 1'b1, '{ANS_READ, 16'd0, 16'd0, 32'd0}},
            '{'{KIND_READ, 8'd0, 8'd8, 16'd0, 16'd0}, 1'b1, '{ANS_READ, 16'd0, 16'd0, 32'd0}},
            '{'{KIND_WRITE, 8'd200, 8'd3, 16'd100, 16'd100}, 1'b0, '0},
            '{'{KIND_READ, 8'd200, 8'd3, 16'd0, 16'd0}, 1'b1, '{ANS_READ, 16'd0, 16'd0, 32'd0}},
            '{'{KIND_WRITE, 8'd3, 8'd3, 16'd16384, 16'd16384}, 1'b0, '0},
            '{'{KIND_WRITE, 8'd0, 8'd0, 16'd0, ONE_Q15}, 1'b0, '0},
            '{'{KIND_WRITE, 8'd7, 8'd7, ONE_Q15, ONE_Q15}, 1'b0, '0},
            '{'{KIND_STEP, 8'd0, 8'd0, 16'd0, 16'd0}, 1'b1, '{ANS_STEP, 16'd0, 16'd0, 32'd1}},
            '{'{KIND_READ, 8'd3, 8'd3, 16'd0, 16'd0}, 1'b0, '0},
            '{'{KIND_READ, 8'd0, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
            '{'{KIND_READ, 8'd7, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
            '{'{KIND_STEP, 8'd0, 8'd0, 16'd0, 16'd0}, 1'b1, '{ANS_STEP, 16'd0, 16'd0, 32'd2}},
            '{'{KIND_READ, 8'd3, 8'd4, 16'd0, 16'd0}, 1'b0, '0}
        };
        settings = '{
            '{16'd3572, 16'd4063, 16'd16384, 16'd8192, 16'd4096, 1'b1, 9'd0, 9'd3, 6},
            '{16'd2300, 16'd5000, 16'd12000, 16'd6000, 16'd8000, 1'b0, 9'd12, 9'd9, 5},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 9'd256, 9'd8, 2},
            '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 9'd8, 9'd511, 2},
            '{16'd1000, 16'd3000, 16'd30000, 16'd20000, 16'd2048, 1'b1, 9'd10, 9'd16, 5}
        };

        for (int i = 0; i < GRID_N * GRID_N; i++) begin
            conc_u[i] = ONE_Q15;
            conc_v[i] = 16'd0;
        end
        step_count = 32'd0;
        p_feed = 16'd3572;
        p_kill = 16'd4063;
        p_du = 16'd16384;
        p_dv = 16'd8192;
        p_dt = 16'd4096;
        p_wrap = 1'b1;
        p_w = 9'd256;
        p_h = 9'd256;
        errors = 0;
        beats_in = 0;
        reads_seen = 0;
        steps_seen = 0;
        burst_left = $urandom_range(1, 8);
        rx_cycle = 0;
        m_ready = 1'b0;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_WRITE;
        s_cell_x = 8'd0;
        s_cell_y = 8'd0;
        s_value_u = 16'd0;
        s_value_v = 16'd0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_FEED;
        cfg_data = 16'd0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < 23; i++) begin
            if (i == 10) apply_setting(settings[0]);
            send_item(rows[i].item, rows[i].typed, rows[i].ans);
        end
        random_items(15, settings[0].max_steps);
        for (int p = 1; p < 5; p++) begin
            apply_setting(settings[p]);
            random_items(15, settings[p].max_steps);
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("covered %0d input beats over 6 register settings", beats_in);
        $display("checked %0d read answers and %0d step answers", reads_seen, steps_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
